@@ design/pfa_pkg.sv @@
// Shared types and constants for the page-frame allocator.
// No dependencies; imported by every other design file except pfa_ram.
`default_nettype none
package pfa_pkg;
    localparam int MAP_DEPTH_DEF   = 4096;
    localparam int CACHE_DEPTH_DEF = 16;

    localparam int OP_W       = 3;
    localparam int PAGE_W     = 12;
    localparam int LEN_W      = 13;
    localparam int MARK_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

    localparam logic [MARK_W-1:0] MARK_FREE   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_CACHED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_USED   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

    localparam logic [CFG_DATA_W-1:0] USABLE_RESET   = 13'd4096;
    localparam logic [CFG_DATA_W-1:0] RESERVED_RESET = 13'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REFILL,
        ST_FIND,
        ST_SWEEP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic sweep;
        logic clear;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_refill;
        logic find_trivial;
        logic scan_done;
        logic sweep_done;
        logic out_free;
    } dp_stat_t;
endpackage
`default_nettype wire

@@ design/pfa_if.sv @@
// Handshake channel interfaces: request, response and configuration write.
// Depends on pfa_pkg for field widths.
`default_nettype none
interface pfa_req_if import pfa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [PAGE_W-1:0] page_number;
    logic [LEN_W-1:0]  run_length;
    modport source (output valid, opcode, page_number, run_length, input ready);
    modport sink   (input valid, opcode, page_number, run_length, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*;;
    logic              valid;
    logic              ready;
    logic              status;
    logic [PAGE_W-1:0] result_page;
    modport source (output valid, status, result_page, input ready);
    modport sink   (input valid, status, result_page, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/pfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module pfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

@@ design/pfa_datapath.sv @@
// Datapath: config registers, page map RAM, page cache, scan counters, result regs.
// Depends on pfa_pkg and pfa_ram; driven by pfa_ctrl through dp_cmd_t.
`default_nettype none
module pfa_datapath import pfa_pkg::*; #(
    parameter int MAP_DEPTH   = MAP_DEPTH_DEF,
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [PAGE_W-1:0]     page_number,
    input  wire logic [LEN_W-1:0]      run_length,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  rsp_ready,
    output logic                       rsp_valid,
    output logic                       rsp_status,
    output logic [PAGE_W-1:0]          rsp_result_page
);
    localparam int AW  = $clog2(MAP_DEPTH);
    localparam int LW  = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int CCW = $clog2(CACHE_DEPTH + 1);
    localparam int CIW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [LW-1:0]  MAP_N = LW'(MAP_DEPTH);
    localparam logic [CCW-1:0] CD_N  = CCW'(CACHE_DEPTH);

    logic [CFG_DATA_W-1:0] usable_reg, reserved_reg;
    logic [OP_W-1:0]       op_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LW-1:0]         addr_reg, paddr_reg, run_reg;
    logic                  pv_reg;
    logic [CCW-1:0]        n_reg, pos_reg, count_reg;
    logic [PAGE_W-1:0]     cache_reg [CACHE_DEPTH];
    logic                  res_status_reg;
    logic [PAGE_W-1:0]     res_page_reg;
    logic                  out_valid_reg, out_status_reg;
    logic [PAGE_W-1:0]     out_page_reg;

    logic [LW-1:0]     lim, usable_ext, page_ext, len_in_ext, len_ext, run_inc;
    logic              issue, eval, is_alloc, mark_free, hit, take, exhausted, scan_done;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [MARK_W-1:0] ram_wdata, ram_rdata;

    pfa_ram #(.WIDTH(MARK_W), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        usable_ext = LW'(usable_reg);
        lim        = (usable_ext < MAP_N) ? usable_ext : MAP_N;
        page_ext   = LW'(page_number);
        len_in_ext = LW'(run_length);
        len_ext    = LW'(len_reg);
        run_inc    = run_reg + LW'(1);
        is_alloc   = (op_reg == OP_ALLOC);
        mark_free  = (ram_rdata == MARK_FREE);
        issue      = cmd.scan && (addr_reg < lim);
        eval       = cmd.scan && pv_reg;
        hit        = eval && !is_alloc && mark_free && (run_inc >= len_ext);
        take       = eval && is_alloc && mark_free && (n_reg < CD_N);
        exhausted  = !pv_reg && (addr_reg >= lim);
        scan_done  = cmd.scan && (is_alloc ? ((n_reg == CD_N) || exhausted)
                                           : (hit || exhausted));

        ram_we    = 1'b0;
        ram_waddr = addr_reg[AW-1:0];
        ram_wdata = MARK_FREE;
        if (cmd.sweep)
        begin
            ram_we    = 1'b1;
            ram_wdata = (!cmd.clear && (addr_reg < LW'(reserved_reg))) ? MARK_USED : MARK_FREE;
        end
        else if (cmd.load && ((opcode == OP_FREE) || (opcode == OP_MARK)) && (page_ext < lim))
        begin
            ram_we    = 1'b1;
            ram_waddr = page_ext[AW-1:0];
            ram_wdata = (opcode == OP_FREE) ? MARK_FREE : MARK_USED;
        end
        else if (take)
        begin
            ram_we    = 1'b1;
            ram_waddr = paddr_reg[AW-1:0];
            ram_wdata = MARK_CACHED;
        end

        stat.need_refill  = (pos_reg >= count_reg);
        stat.find_trivial = (run_length == '0) || (len_in_ext > lim);
        stat.scan_done    = scan_done;
        stat.sweep_done   = cmd.sweep && (addr_reg == MAP_N - LW'(1));
        stat.out_free     = !out_valid_reg || rsp_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usable_reg    <= USABLE_RESET;
            reserved_reg  <= RESERVED_RESET;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_USABLE:   usable_reg   <= cfg_data;
                    CFG_RESERVED: reserved_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                addr_reg <= '0;
                pv_reg   <= 1'b0;
                if (opcode == OP_INIT)
                begin
                    pos_reg   <= '0;
                    count_reg <= '0;
                end
            end
            if (cmd.scan)
            begin
                pv_reg <= issue;
                if (issue)
                begin
                    addr_reg <= addr_reg + LW'(1);
                end
                if (scan_done && is_alloc && (n_reg != '0))
                begin
                    count_reg <= n_reg;
                    pos_reg   <= '0;
                end
            end
            if (cmd.sweep)
            begin
                addr_reg <= stat.sweep_done ? '0 : addr_reg + LW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (is_alloc && (pos_reg < count_reg))
                begin
                    pos_reg <= pos_reg + CCW'(1);
                end
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= opcode;
            len_reg        <= run_length;
            run_reg        <= '0;
            n_reg          <= '0;
            res_status_reg <= (opcode == OP_FIND) && (len_in_ext > lim);
            res_page_reg   <= '0;
        end
        if (cmd.scan)
        begin
            paddr_reg <= addr_reg;
            if (eval && !is_alloc)
            begin
                run_reg <= mark_free ? run_inc : '0;
            end
            if (take)
            begin
                cache_reg[n_reg[CIW-1:0]] <= PAGE_W'(paddr_reg);
                n_reg <= n_reg + CCW'(1);
            end
            if (hit)
            begin
                res_page_reg <= PAGE_W'(paddr_reg + LW'(1) - len_ext);
            end
            else if (scan_done && !is_alloc)
            begin
                res_status_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            if (is_alloc)
            begin
                // pop the cache or report an empty one
                if (pos_reg < count_reg)
                begin
                    out_status_reg <= 1'b0;
                    out_page_reg   <= cache_reg[pos_reg[CIW-1:0]];
                end
                else
                begin
                    out_status_reg <= 1'b1;
                    out_page_reg   <= '0;
                end
            end
            else
            begin
                out_status_reg <= res_status_reg;
                out_page_reg   <= res_page_reg;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_result_page = out_page_reg;
endmodule
`default_nettype wire

@@ design/pfa_ctrl.sv @@
// Controller state machine: sequences accept, map scans, sweeps and response.
// Depends on pfa_pkg; talks to pfa_datapath through dp_cmd_t and dp_stat_t.
`default_nettype none
module pfa_ctrl import pfa_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic [OP_W-1:0] opcode,
    output logic                 req_ready,
    output dp_cmd_t              cmd,
    input  wire dp_stat_t        stat
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                cmd.clear = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (opcode)
                        OP_ALLOC: state_next = stat.need_refill ? ST_REFILL : ST_RESP;
                        OP_FIND:  state_next = stat.find_trivial ? ST_RESP : ST_FIND;
                        OP_INIT:  state_next = ST_SWEEP;
                        default:  state_next = ST_RESP;
                    endcase
                end
            end
            ST_REFILL, ST_FIND:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // hold until the output register can take the beat
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ design/page_frame_allocator_with_cache_core.sv @@
// Top level of the page-frame allocator with a page cache.
// Depends on pfa_pkg, pfa_if, pfa_ctrl and pfa_datapath.
//
// Usage: requests arrive on req (opcode, page_number, run_length), one
// response beat per request leaves on rsp (status, result_page). The cfg
// channel writes usable_pages (index 0) and reserved_pages (index 1); it is
// always ready. The user must write it only while no request is in flight;
// the block does not enforce this. After reset the block clears all MAP_DEPTH
// map entries (4096 by default), one per cycle; req.ready is low until done.
// One request is worked on at a time. Free, mark and unused opcodes and an
// allocate served from the cache go from accept straight to the response;
// a cache refill or run search scans up to min(usable_pages, MAP_DEPTH)
// map entries through its single read port; init rewrites the whole map.
// The response sits in an output register: while the receiver stalls the
// next request is still accepted and worked on, and its result waits until
// the register is taken.
`default_nettype none
module page_frame_allocator_with_cache_core import pfa_pkg::*; #(
    parameter int MAP_DEPTH   = MAP_DEPTH_DEF,
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pfa_cfg_if.sink   cfg,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .opcode    (req.opcode),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pfa_datapath #(.MAP_DEPTH(MAP_DEPTH), .CACHE_DEPTH(CACHE_DEPTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .opcode          (req.opcode),
        .page_number     (req.page_number),
        .run_length      (req.run_length),
        .cmd             (cmd),
        .stat            (stat),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_result_page (rsp.result_page)
    );
endmodule
`default_nettype wire

@@ design/pfa_checker.sv @@
// Port-level checks for the page-frame allocator top level, and their bind.
// Depends on pfa_pkg and page_frame_allocator_with_cache_core.
`default_nettype none
module pfa_checker import pfa_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              rsp_status,
    input wire logic [PAGE_W-1:0] rsp_result_page
);
    // one request in flight: ready drops right after an accepted beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted twice in a row");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status) |-> (rsp_result_page == '0))
        else $error("failed response carries a nonzero page");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(rsp_status) && $stable(rsp_result_page)))
        else $error("response payload changed while stalled");
endmodule

bind page_frame_allocator_with_cache_core pfa_checker u_pfa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_result_page (rsp.result_page)
);
`default_nettype wire
